// ===== rtl/lbft_pkg.sv =====
// Shared types and codes for the learning bridge forwarding table.
// Used by the entry cells, the output stage, the top level and the checker.
package lbft_pkg;

    localparam int ADDRESS_BITS_DEFAULT = 8;
    localparam int ADDR_W = 8;
    localparam int PORT_W = 4;
    localparam int AGE_W = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_INDEX_W = 1;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd15;
    localparam logic [ADDR_W-1:0] BROADCAST_RESET = 8'd70;

    typedef enum logic [1:0] {
        DEC_FORWARD = 2'd0,
        DEC_FILTER  = 2'd1,
        DEC_FLOOD   = 2'd2
    } t_decision;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_TICK  = 1'b1
    } t_command;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_AGE   = 1'b0,
        CFG_BROADCAST = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              valid;
        logic              tick;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [PORT_W-1:0] port;
        logic              bcast;
        logic              src_new;
        logic              dst_hit;
        logic [PORT_W-1:0] dst_port;
    } t_req;

endpackage

// ===== rtl/learning_bridge_forward_table.sv =====
// Top level of the learning bridge forwarding table with aging.
// Depends on lbft_pkg, lbft_cell and lbft_out.
//
// Requests enter on i_valid/o_ready. A frame request (command 0) learns its
// source address and yields one result on o_valid/i_ready: decision, egress
// port and whether the source was new. A tick request (command 1) ages every
// valid entry by one and yields no result.
// Each table entry lives in its own cell, and the cells form a chain of
// 2^ADDRESS_BITS stages. A request visits one cell per cycle while the chain
// advances, and its result is registered in the output stage. A new request
// of either kind is accepted every cycle that o_ready is high. Requests pass
// every cell in order, so each sees all the learning and aging of earlier ones.
// When the receiver stalls, the result is held and the whole chain stops;
// o_ready drops until the result is taken.
// Synchronous reset clears all entries' valid bits and the chain, and restores
// max_age to 15 and the broadcast address to 70.
// Configuration writes are taken on any cycle out of reset with i_cfg_we high.
module learning_bridge_forward_table import lbft_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_command,
    input  logic [ADDR_W-1:0]      i_source_address,
    input  logic [ADDR_W-1:0]      i_destination_address,
    input  logic [PORT_W-1:0]      i_arrival_port,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_decision,
    output logic [PORT_W-1:0]      o_egress_port,
    output logic                   o_source_was_new,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int TABLE_SIZE = 1 << ADDRESS_BITS;

    logic [AGE_W-1:0]  r_max_age;
    logic [ADDR_W-1:0] r_broadcast;
    logic              w_advance;
    t_req              w_head;
    t_req              w_chain [0:TABLE_SIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age   <= MAX_AGE_RESET;
            r_broadcast <= BROADCAST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_AGE:   r_max_age   <= AGE_W'(i_cfg_data);
                CFG_BROADCAST: r_broadcast <= ADDR_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        w_head.valid    = i_valid;
        w_head.tick     = (i_command == CMD_TICK);
        w_head.src      = i_source_address;
        w_head.dst      = i_destination_address;
        w_head.port     = i_arrival_port;
        w_head.bcast    = (i_destination_address == r_broadcast);
        w_head.src_new  = 1'b0;
        w_head.dst_hit  = 1'b0;
        w_head.dst_port = '0;
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_entry
        lbft_cell #(
            .ADDRESS_BITS(ADDRESS_BITS),
            .CELL_INDEX  (g)
        ) u_entry (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_advance(w_advance),
            .i_max_age(r_max_age),
            .i_req    (w_chain[g]),
            .o_req    (w_chain[g+1])
        );
    end

    lbft_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (w_chain[TABLE_SIZE]),
        .i_ready         (i_ready),
        .o_advance       (w_advance),
        .o_valid         (o_valid),
        .o_decision      (o_decision),
        .o_egress_port   (o_egress_port),
        .o_source_was_new(o_source_was_new)
    );

    assign o_ready = w_advance;

endmodule

// ===== rtl/lbft_cell.sv =====
// One table entry of the forwarding table chain: learns, looks up and ages
// its own entry as a request passes through. Depends on lbft_pkg.
module lbft_cell import lbft_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
    parameter int CELL_INDEX   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [AGE_W-1:0] i_max_age,
    input  t_req             i_req,
    output t_req             o_req
);

    logic              r_valid;
    logic              n_valid;
    logic [PORT_W-1:0] r_port;
    logic [PORT_W-1:0] n_port;
    logic [AGE_W-1:0]  r_age;
    logic [AGE_W-1:0]  n_age;
    logic              r_req_valid;
    t_req              r_req;
    t_req              n_req;

    logic src_match;
    logic dst_match;
    logic is_frame;
    logic is_tick;
    logic learned_valid;
    logic [PORT_W-1:0] learned_port;

    always_comb begin
        is_frame  = i_req.valid && !i_req.tick;
        is_tick   = i_req.valid && i_req.tick;
        src_match = is_frame &&
                    (ADDRESS_BITS'(i_req.src) == ADDRESS_BITS'(CELL_INDEX));
        dst_match = is_frame &&
                    (ADDRESS_BITS'(i_req.dst) == ADDRESS_BITS'(CELL_INDEX));

        learned_valid = src_match || r_valid;
        learned_port  = src_match ? i_req.port : r_port;

        n_req = i_req;
        n_req.src_new = i_req.src_new || (src_match && !r_valid);
        if (dst_match) begin
            n_req.dst_hit  = learned_valid;
            n_req.dst_port = learned_port;
        end

        n_valid = r_valid;
        n_port  = r_port;
        n_age   = r_age;
        if (src_match) begin
            n_valid = 1'b1;
            n_port  = i_req.port;
            n_age   = i_max_age;
        end else if (is_tick && r_valid) begin
            if (r_age <= AGE_W'(1)) begin
                n_valid = 1'b0;
            end else begin
                n_age = r_age - AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_req_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid     <= n_valid;
            r_req_valid <= n_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_port <= n_port;
            r_age  <= n_age;
            r_req  <= n_req;
        end
    end

    always_comb begin
        o_req       = r_req;
        o_req.valid = r_req_valid;
    end

endmodule

// ===== rtl/lbft_out.sv =====
// Output stage: turns a finished lookup into a forwarding decision and holds
// it until the receiver takes it. Depends on lbft_pkg.
module lbft_out import lbft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req,
    input  logic              i_ready,
    output logic              o_advance,
    output logic              o_valid,
    output logic [1:0]        o_decision,
    output logic [PORT_W-1:0] o_egress_port,
    output logic              o_source_was_new
);

    logic              r_valid;
    t_decision         r_decision;
    logic [PORT_W-1:0] r_egress;
    logic              r_src_new;
    t_decision         n_decision;
    logic [PORT_W-1:0] n_egress;

    assign o_advance = !r_valid || i_ready;

    always_comb begin
        n_egress = i_req.port;
        if (i_req.bcast || !i_req.dst_hit) begin
            n_decision = DEC_FLOOD;
        end else if (i_req.dst_port == i_req.port) begin
            n_decision = DEC_FILTER;
        end else begin
            n_decision = DEC_FORWARD;
            n_egress   = i_req.dst_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_req.valid && !i_req.tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_decision <= n_decision;
            r_egress   <= n_egress;
            r_src_new  <= i_req.src_new;
        end
    end

    assign o_valid          = r_valid;
    assign o_decision       = r_decision;
    assign o_egress_port    = r_egress;
    assign o_source_was_new = r_src_new;

endmodule

// ===== rtl/lbft_checker.sv =====
// Port-level checks for the learning bridge forwarding table, bound to the
// top level. Depends on lbft_pkg and learning_bridge_forward_table.
module lbft_checker import lbft_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [1:0]        o_decision,
    input logic [PORT_W-1:0] o_egress_port,
    input logic              o_source_was_new
);

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_decision_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_decision == DEC_FORWARD || o_decision == DEC_FILTER ||
                     o_decision == DEC_FLOOD))
        else $error("undefined decision code");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("request taken while a result is stalled");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_decision) &&
                                   $stable(o_egress_port) &&
                                   $stable(o_source_was_new)))
        else $error("stalled result changed");

endmodule

bind learning_bridge_forward_table lbft_checker u_checker (.*);
